// ----- rtl/urb_pkg.sv -----
// ----------------------------------------------------------------------------
// urb_pkg
// Shared types, widths and reset values for the ultrasonic ranger and blinker.
// ----------------------------------------------------------------------------
package urb_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam int TRIG_W   = 10;
    localparam int MAXE_W   = 16;
    localparam int TPC_W    = 8;
    localparam int DIST_W   = 10;
    localparam int HALF_W   = 20;
    localparam int TIMER_W  = 20;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 3;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [TRIG_W-1:0] RST_TRIGGER_TICKS    = TRIG_W'(10);
    localparam logic [MAXE_W-1:0] RST_MAX_ECHO_TICKS   = MAXE_W'(38000);
    localparam logic [TPC_W-1:0]  RST_TICKS_PER_CM     = TPC_W'(59);
    localparam logic [DIST_W-1:0] RST_NEAR_LIMIT_CM    = DIST_W'(15);
    localparam logic [DIST_W-1:0] RST_FAR_LIMIT_CM     = DIST_W'(35);
    localparam logic [HALF_W-1:0] RST_NEAR_HALF_PERIOD = HALF_W'(100000);
    localparam logic [HALF_W-1:0] RST_MID_HALF_PERIOD  = HALF_W'(500000);
    localparam logic [HALF_W-1:0] RST_FAR_HALF_PERIOD  = HALF_W'(1000000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIGGER_TICKS    = 3'd0,
        CFG_MAX_ECHO_TICKS   = 3'd1,
        CFG_TICKS_PER_CM     = 3'd2,
        CFG_NEAR_LIMIT_CM    = 3'd3,
        CFG_FAR_LIMIT_CM     = 3'd4,
        CFG_NEAR_HALF_PERIOD = 3'd5,
        CFG_MID_HALF_PERIOD  = 3'd6,
        CFG_FAR_HALF_PERIOD  = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_TRIGGER = 3'd0,
        PH_RISE    = 3'd1,
        PH_FALL    = 3'd2,
        PH_LED_ON  = 3'd3,
        PH_LED_OFF = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        BAND_NONE = 2'd0,
        BAND_NEAR = 2'd1,
        BAND_MID  = 2'd2,
        BAND_FAR  = 2'd3
    } t_band;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_DIV  = 2'd1,
        S_OUT  = 2'd2
    } t_seq_state;

    typedef struct packed {
        logic [TRIG_W-1:0] trigger_ticks;
        logic [MAXE_W-1:0] max_echo_ticks;
        logic [TPC_W-1:0]  ticks_per_cm;
        logic [DIST_W-1:0] near_limit_cm;
        logic [DIST_W-1:0] far_limit_cm;
        logic [HALF_W-1:0] near_half_period;
        logic [HALF_W-1:0] mid_half_period;
        logic [HALF_W-1:0] far_half_period;
    } t_cfg;

endpackage

// ----- rtl/urb_if.sv -----
// ----------------------------------------------------------------------------
// urb_if
// Valid/ready channels for echo samples and ranger results.
// ----------------------------------------------------------------------------
interface urb_in_if;
    logic valid;
    logic ready;
    logic echo_level;

    modport source (output valid, output echo_level, input ready);
    modport sink   (input valid, input echo_level, output ready);
endinterface

interface urb_out_if;
    logic                      valid;
    logic                      ready;
    logic                      trigger_out;
    logic                      led_out;
    logic [urb_pkg::DIST_W-1:0] distance_cm;
    logic                      distance_valid;
    logic                      stop_warning;

    modport source (output valid, output trigger_out, output led_out, output distance_cm,
                    output distance_valid, output stop_warning, input ready);
    modport sink   (input valid, input trigger_out, input led_out, input distance_cm,
                    input distance_valid, input stop_warning, output ready);
endinterface

// ----- rtl/urb_div.sv -----
// ----------------------------------------------------------------------------
// urb_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module urb_div #(
    parameter int COUNT_BITS = urb_pkg::COUNT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [COUNT_BITS-1:0]      i_dividend,
    input  logic [urb_pkg::TPC_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [COUNT_BITS-1:0]      o_quotient
);
    localparam int CNT_W = $clog2(COUNT_BITS + 1);
    localparam int DV_W  = urb_pkg::TPC_W;

    logic [DV_W:0]         r_rem,  n_rem;
    logic [COUNT_BITS-1:0] r_quo,  n_quo;
    logic [DV_W-1:0]       r_dvs,  n_dvs;
    logic [CNT_W-1:0]      r_cnt,  n_cnt;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;

    logic [DV_W:0]   shifted;
    logic [DV_W+1:0] diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    always_comb begin
        shifted = {r_rem[DV_W-1:0], r_quo[COUNT_BITS-1]};
        diff    = {1'b0, shifted} - {2'b00, r_dvs};
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
            n_cnt  = CNT_W'(COUNT_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!diff[DV_W+1]) begin
                n_rem = diff[DV_W:0];
            end else begin
                n_rem = shifted;
            end
            n_quo = {r_quo[COUNT_BITS-2:0], ~diff[DV_W+1]};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/urb_seq.sv -----
// ----------------------------------------------------------------------------
// urb_seq
// Measurement and blink sequencer, one echo sample per request.
// ----------------------------------------------------------------------------
module urb_seq #(
    parameter int COUNT_BITS = urb_pkg::COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  urb_pkg::t_cfg       i_cfg,
    urb_in_if.sink              in_chan,
    urb_out_if.source           out_chan
);
    localparam int CMP_W = (COUNT_BITS > urb_pkg::MAXE_W) ? COUNT_BITS : urb_pkg::MAXE_W;
    localparam int TW    = urb_pkg::TIMER_W;
    localparam int DW    = urb_pkg::DIST_W;

    urb_pkg::t_seq_state    r_state, n_state;
    urb_pkg::t_phase        r_phase, n_phase;
    urb_pkg::t_band         r_band,  n_band;
    logic [COUNT_BITS-1:0]  r_count, n_count;
    logic [TW-1:0]          r_timer, n_timer;
    logic [DW-1:0]          r_dist,  n_dist;
    logic                   r_trig,  n_trig;
    logic                   r_led,   n_led;
    logic                   r_valid, n_valid;
    logic                   r_warn,  n_warn;

    logic                   div_start;
    logic                   div_done;
    logic [COUNT_BITS-1:0]  div_quo;
    logic [COUNT_BITS-1:0]  count_inc;
    logic [TW-1:0]          timer_inc;
    logic [TW-1:0]          half;
    logic [DW-1:0]          range_cm;
    urb_pkg::t_band         band_sel;

    urb_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (count_inc),
        .i_divisor  (i_cfg.ticks_per_cm),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= urb_pkg::S_IDLE;
            r_phase <= urb_pkg::PH_TRIGGER;
            r_band  <= urb_pkg::BAND_NONE;
            r_count <= '0;
            r_timer <= '0;
            r_dist  <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_band  <= n_band;
            r_count <= n_count;
            r_timer <= n_timer;
            r_dist  <= n_dist;
        end
        r_trig  <= n_trig;
        r_led   <= n_led;
        r_valid <= n_valid;
        r_warn  <= n_warn;
    end

    always_comb begin
        count_inc = (r_count == {COUNT_BITS{1'b1}}) ? r_count : r_count + 1'b1;
        timer_inc = r_timer + 1'b1;

        case (r_band)
            urb_pkg::BAND_NEAR: half = i_cfg.near_half_period;
            urb_pkg::BAND_MID:  half = i_cfg.mid_half_period;
            default:            half = i_cfg.far_half_period;
        endcase

        // distance from the finished count
        if (CMP_W'(r_count) >= CMP_W'(i_cfg.max_echo_ticks)) begin
            range_cm = '0;
        end else if (div_quo[COUNT_BITS-1:DW] != '0) begin
            range_cm = urb_pkg::DIST_MAX;
        end else begin
            range_cm = div_quo[DW-1:0];
        end

        if (range_cm < i_cfg.near_limit_cm) begin
            band_sel = urb_pkg::BAND_NEAR;
        end else if (range_cm > i_cfg.near_limit_cm && range_cm < i_cfg.far_limit_cm) begin
            band_sel = urb_pkg::BAND_MID;
        end else if (range_cm > i_cfg.far_limit_cm) begin
            band_sel = urb_pkg::BAND_FAR;
        end else begin
            band_sel = urb_pkg::BAND_NONE;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_band    = r_band;
        n_count   = r_count;
        n_timer   = r_timer;
        n_dist    = r_dist;
        n_trig    = r_trig;
        n_led     = r_led;
        n_valid   = r_valid;
        n_warn    = r_warn;
        div_start = 1'b0;

        case (r_state)
            urb_pkg::S_IDLE: begin
                if (in_chan.valid) begin
                    n_trig  = 1'b0;
                    n_led   = 1'b0;
                    n_valid = 1'b0;
                    n_warn  = 1'b0;
                    n_state = urb_pkg::S_OUT;
                    case (r_phase)
                        urb_pkg::PH_TRIGGER: begin
                            n_trig  = 1'b1;
                            n_count = count_inc;
                            n_timer = timer_inc;
                            if (timer_inc >= TW'(i_cfg.trigger_ticks)) begin
                                n_phase = urb_pkg::PH_RISE;
                                n_timer = '0;
                            end
                        end
                        urb_pkg::PH_RISE: begin
                            n_count = count_inc;
                            if (in_chan.echo_level) begin
                                n_phase = urb_pkg::PH_FALL;
                            end
                        end
                        urb_pkg::PH_FALL: begin
                            n_count = count_inc;
                            if (!in_chan.echo_level) begin
                                div_start = 1'b1;
                                n_state   = urb_pkg::S_DIV;
                            end
                        end
                        urb_pkg::PH_LED_ON: begin
                            n_led   = 1'b1;
                            n_warn  = (r_band == urb_pkg::BAND_NEAR);
                            n_timer = timer_inc;
                            if (timer_inc >= half) begin
                                n_phase = urb_pkg::PH_LED_OFF;
                                n_timer = '0;
                            end
                        end
                        urb_pkg::PH_LED_OFF: begin
                            n_warn  = (r_band == urb_pkg::BAND_NEAR);
                            n_timer = timer_inc;
                            if (timer_inc >= half) begin
                                n_phase = urb_pkg::PH_TRIGGER;
                                n_count = '0;
                                n_timer = '0;
                            end
                        end
                        default: begin
                            n_phase = urb_pkg::PH_TRIGGER;
                            n_count = '0;
                            n_timer = '0;
                        end
                    endcase
                end
            end
            urb_pkg::S_DIV: begin
                if (div_done) begin
                    n_dist  = range_cm;
                    n_valid = 1'b1;
                    n_band  = band_sel;
                    n_state = urb_pkg::S_OUT;
                    if (band_sel == urb_pkg::BAND_NONE) begin
                        n_phase = urb_pkg::PH_TRIGGER;
                        n_count = '0;
                        n_timer = '0;
                    end else begin
                        n_phase = urb_pkg::PH_LED_ON;
                        n_timer = '0;
                    end
                end
            end
            urb_pkg::S_OUT: begin
                if (out_chan.ready) begin
                    n_state = urb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = urb_pkg::S_IDLE;
            end
        endcase
    end

    assign in_chan.ready           = (r_state == urb_pkg::S_IDLE);
    assign out_chan.valid          = (r_state == urb_pkg::S_OUT);
    assign out_chan.trigger_out    = r_trig;
    assign out_chan.led_out        = r_led;
    assign out_chan.distance_cm    = r_dist;
    assign out_chan.distance_valid = r_valid;
    assign out_chan.stop_warning   = r_warn;

endmodule

// ----- rtl/ultrasonic_range_blink_ctrl.sv -----
// The result of a request can be taken in the cycle after it; after the echo-fall
// sample the result passes through the divider (S_DIV) before S_OUT presents it.
// A new request is taken only in S_IDLE, after the last result has been taken; the
// echo-fall sample holds the input while the divider makes one quotient bit per cycle.
// reset: synchronous active-low, restarts in trigger phase with default settings
// ----------------------------------------------------------------------------
// ultrasonic_range_blink_ctrl
// Ultrasonic echo ranger with distance-band LED blink control.
// ----------------------------------------------------------------------------
module ultrasonic_range_blink_ctrl #(
    parameter int COUNT_BITS = urb_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    urb_in_if.sink                        in_chan,
    urb_out_if.source                     out_chan,
    input  logic                          i_cfg_wr_en,
    input  logic [urb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [urb_pkg::CFG_W-1:0]     i_cfg_wdata
);
    urb_pkg::t_cfg r_cfg, n_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_ticks    <= urb_pkg::RST_TRIGGER_TICKS;
            r_cfg.max_echo_ticks   <= urb_pkg::RST_MAX_ECHO_TICKS;
            r_cfg.ticks_per_cm     <= urb_pkg::RST_TICKS_PER_CM;
            r_cfg.near_limit_cm    <= urb_pkg::RST_NEAR_LIMIT_CM;
            r_cfg.far_limit_cm     <= urb_pkg::RST_FAR_LIMIT_CM;
            r_cfg.near_half_period <= urb_pkg::RST_NEAR_HALF_PERIOD;
            r_cfg.mid_half_period  <= urb_pkg::RST_MID_HALF_PERIOD;
            r_cfg.far_half_period  <= urb_pkg::RST_FAR_HALF_PERIOD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (urb_pkg::t_cfg_idx'(i_cfg_index))
                urb_pkg::CFG_TRIGGER_TICKS:
                    n_cfg.trigger_ticks = i_cfg_wdata[urb_pkg::TRIG_W-1:0];
                urb_pkg::CFG_MAX_ECHO_TICKS:
                    n_cfg.max_echo_ticks = i_cfg_wdata[urb_pkg::MAXE_W-1:0];
                urb_pkg::CFG_TICKS_PER_CM:
                    n_cfg.ticks_per_cm = i_cfg_wdata[urb_pkg::TPC_W-1:0];
                urb_pkg::CFG_NEAR_LIMIT_CM:
                    n_cfg.near_limit_cm = i_cfg_wdata[urb_pkg::DIST_W-1:0];
                urb_pkg::CFG_FAR_LIMIT_CM:
                    n_cfg.far_limit_cm = i_cfg_wdata[urb_pkg::DIST_W-1:0];
                urb_pkg::CFG_NEAR_HALF_PERIOD:
                    n_cfg.near_half_period = i_cfg_wdata[urb_pkg::HALF_W-1:0];
                urb_pkg::CFG_MID_HALF_PERIOD:
                    n_cfg.mid_half_period = i_cfg_wdata[urb_pkg::HALF_W-1:0];
                urb_pkg::CFG_FAR_HALF_PERIOD:
                    n_cfg.far_half_period = i_cfg_wdata[urb_pkg::HALF_W-1:0];
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    urb_seq #(
        .COUNT_BITS (COUNT_BITS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .in_chan  (in_chan),
        .out_chan (out_chan)
    );

endmodule
